[rtl/ima_enc_pkg.sv]
package ima_enc_pkg;

  localparam int unsigned MAX_BLOCK_BYTES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF     = 4;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SIZE_CFG_W = 13;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned STEP_W    = 15;
  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned MIN_BLOCK_BYTES = 8;

  localparam logic [SIZE_CFG_W-1:0] BLOCK_BYTES_RST = 13'd512;
  localparam logic [IDX_W-1:0]      STEP_IDX_MAX    = 7'd88;
  localparam logic [7:0]            HDR_PAD_BYTE    = 8'h00;

  // header beat positions
  localparam logic [1:0] BEAT_LO  = 2'd0;
  localparam logic [1:0] BEAT_HI  = 2'd1;
  localparam logic [1:0] BEAT_IDX = 2'd2;
  localparam logic [1:0] BEAT_PAD = 2'd3;

  localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,    15'd14,
    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,    15'd31,
    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
    15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,   15'd130,   15'd143,
    15'd157,   15'd173,   15'd190,   15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
    15'd337,   15'd371,   15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
    15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,  15'd3024,
    15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
    15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  // one queued job: a header sample or a finished data byte
  typedef struct packed {
    logic                is_hdr;
    logic [SAMPLE_W-1:0] word;     // header: sample, data: byte in low bits
    logic [IDX_W-1:0]    step_index;
    logic                blk_end;
  } job_t;

  function automatic logic [STEP_W-1:0] step_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] idx_c;
    idx_c = (idx > STEP_IDX_MAX) ? STEP_IDX_MAX : idx;
    return STEP_TABLE[idx_c];
  endfunction

  function automatic logic signed [4:0] idx_adj(input logic [2:0] mag);
    logic signed [4:0] adj;
    case (mag)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

endpackage

[rtl/ima_adpcm_block_encoder.sv]
// path: a sample that completes a byte or opens a block is written into the job queue
//   and from the queue head loaded into the registered output stage
// throughput: one sample per cycle while the queue has room; a header sample needs
//   four output beats, data one beat per two samples, the job queue absorbs the burst
// reset: synchronous, active high; predictor, step index and block position clear,
//   block size returns to 512 bytes, queue and output stage empty
module ima_adpcm_block_encoder #(
  parameter int unsigned MAX_BLOCK_BYTES = ima_enc_pkg::MAX_BLOCK_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH     = ima_enc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // block size register write
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ima_enc_pkg::SIZE_CFG_W-1:0]      block_bytes,
  // pcm sample in
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [ima_enc_pkg::SAMPLE_W-1:0] sample,
  // encoded byte stream out
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [7:0]                              out_byte,
  output logic                                    last_of_run,
  output logic                                    block_end
);

  logic [ima_enc_pkg::SIZE_CFG_W-1:0] blk_size;
  logic              q_full, push, pop, head_valid;
  ima_enc_pkg::job_t push_job, head;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_size <= ima_enc_pkg::BLOCK_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      blk_size <= block_bytes;
    end
  end

  // front: block position, header detection, quantize and rebuild, nibble pairing
  ima_enc_front #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .blk_size (blk_size),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sample   (sample),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // jobs waiting for the byte serializer
  ima_enc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: turns each job into one or four registered output beats
  ima_enc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .block_end   (block_end)
  );

endmodule

[rtl/ima_enc_front.sv]
module ima_enc_front #(
  parameter int unsigned MAX_BLOCK_BYTES = ima_enc_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [ima_enc_pkg::SIZE_CFG_W-1:0]     blk_size,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ima_enc_pkg::SAMPLE_W-1:0] sample,
  input  logic                                   q_full,
  output logic                                   push,
  output ima_enc_pkg::job_t                      push_job
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int unsigned SZ_W  = (CNT_W > ima_enc_pkg::SIZE_CFG_W) ?
                                  CNT_W : ima_enc_pkg::SIZE_CFG_W;

  logic signed [15:0] predictor;
  logic [6:0]         step_index;
  logic [3:0]         held_nibble;
  logic               nibble_phase;
  logic [CNT_W-1:0]   byte_count;

  logic               accept, at_hdr;
  logic [16:0]        step, diff, mag, d1, d2, delta;
  logic               neg, b2, b1, b0;
  logic [3:0]         code;
  logic signed [17:0] pred_sum;
  logic signed [15:0] pred_next;
  logic signed [7:0]  idx_sum;
  logic [6:0]         idx_next;
  logic [SZ_W-1:0]    eff_size, size_ext, count_inc;
  logic               blk_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign at_hdr   = (byte_count == '0);

  // quantize against the current step, three compare steps, the first two with a subtract
  always_comb begin
    step  = 17'(ima_enc_pkg::step_of(step_index));
    diff  = {sample[15], sample} - {predictor[15], predictor};
    neg   = diff[16];
    mag   = neg ? (~diff + 17'd1) : diff;
    b2    = (mag >= step);
    d1    = b2 ? (mag - step) : mag;
    b1    = (d1 >= (step >> 1));
    d2    = b1 ? (d1 - (step >> 1)) : d1;
    b0    = (d2 >= (step >> 2));
    code  = {neg, b2, b1, b0};
    delta = (step >> 3) + (b2 ? step : 17'd0) + (b1 ? (step >> 1) : 17'd0)
          + (b0 ? (step >> 2) : 17'd0);
    pred_sum = neg ? ($signed({{2{predictor[15]}}, predictor}) - $signed({1'b0, delta}))
                   : ($signed({{2{predictor[15]}}, predictor}) + $signed({1'b0, delta}));
    if (pred_sum > 18'sd32767) begin
      pred_next = 16'sh7fff;
    end else if (pred_sum < -18'sd32768) begin
      pred_next = 16'sh8000;
    end else begin
      pred_next = pred_sum[15:0];
    end
    idx_sum = $signed({1'b0, step_index}) + 8'(ima_enc_pkg::idx_adj(code[2:0]));
    if (idx_sum < 8'sd0) begin
      idx_next = '0;
    end else if (idx_sum > $signed({1'b0, ima_enc_pkg::STEP_IDX_MAX})) begin
      idx_next = ima_enc_pkg::STEP_IDX_MAX;
    end else begin
      idx_next = idx_sum[6:0];
    end
  end

  // block size saturated to min..max
  always_comb begin
    size_ext  = SZ_W'(blk_size);
    eff_size  = size_ext;
    if (size_ext > SZ_W'(MAX_BLOCK_BYTES)) eff_size = SZ_W'(MAX_BLOCK_BYTES);
    if (eff_size < SZ_W'(ima_enc_pkg::MIN_BLOCK_BYTES)) begin
      eff_size = SZ_W'(ima_enc_pkg::MIN_BLOCK_BYTES);
    end
    count_inc = SZ_W'(byte_count) + SZ_W'(1);
    blk_end   = (count_inc >= eff_size);
  end

  always_comb begin
    push                = accept && (at_hdr || nibble_phase);
    push_job.is_hdr     = at_hdr;
    push_job.word       = at_hdr ? sample : {8'h00, code, held_nibble};
    push_job.step_index = step_index;
    push_job.blk_end    = !at_hdr && blk_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor    <= '0;
      step_index   <= '0;
      held_nibble  <= '0;
      nibble_phase <= 1'b0;
      byte_count   <= '0;
    end else if (accept) begin
      if (at_hdr) begin
        predictor    <= sample;
        held_nibble  <= '0;
        nibble_phase <= 1'b0;
        byte_count   <= CNT_W'(ima_enc_pkg::HDR_BYTES);
      end else begin
        predictor  <= pred_next;
        step_index <= idx_next;
        if (!nibble_phase) begin
          held_nibble  <= code;
          nibble_phase <= 1'b1;
        end else begin
          held_nibble  <= '0;
          nibble_phase <= 1'b0;
          byte_count   <= blk_end ? '0 : count_inc[CNT_W-1:0];
        end
      end
    end
  end

endmodule

[rtl/ima_enc_queue.sv]
module ima_enc_queue #(
  parameter int unsigned DEPTH = ima_enc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ima_enc_pkg::job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ima_enc_pkg::job_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ima_enc_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push, do_pop;

  assign full       = (fill == CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      fill <= fill + CNT_W'(1);
      else if (do_pop && !do_push) fill <= fill - CNT_W'(1);
    end
  end

endmodule

[rtl/ima_enc_back.sv]
module ima_enc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  ima_enc_pkg::job_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              last_of_run,
  output logic              block_end
);

  logic [1:0] beat;
  logic       load, hdr_done;
  logic [7:0] byte_sel;

  assign load     = head_valid && (!out_valid || out_ready);
  assign hdr_done = (beat == ima_enc_pkg::BEAT_PAD);
  assign pop      = load && (!head.is_hdr || hdr_done);

  always_comb begin
    if (head.is_hdr) begin
      case (beat)
        ima_enc_pkg::BEAT_LO:  byte_sel = head.word[7:0];
        ima_enc_pkg::BEAT_HI:  byte_sel = head.word[15:8];
        ima_enc_pkg::BEAT_IDX: byte_sel = {1'b0, head.step_index};
        default:               byte_sel = ima_enc_pkg::HDR_PAD_BYTE;
      endcase
    end else begin
      byte_sel = head.word[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= byte_sel;
      last_of_run <= !head.is_hdr || hdr_done;
      block_end   <= !head.is_hdr && head.blk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= ima_enc_pkg::BEAT_LO;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load && head.is_hdr) begin
        beat <= hdr_done ? ima_enc_pkg::BEAT_LO : beat + 2'd1;
      end
    end
  end

  a_beat_in_hdr: assert property (@(posedge clk) disable iff (rst)
    (beat != ima_enc_pkg::BEAT_LO) |-> (head_valid && head.is_hdr))
    else $error("header beat count running without a header at the queue head");

  a_hdr_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && head.is_hdr) |-> (beat == ima_enc_pkg::BEAT_PAD))
    else $error("header job released before its four beats");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_end) |-> last_of_run)
    else $error("block end flagged on a byte that does not close its sample");

endmodule
